// ===== design/rmmq_pkg.sv =====
package rmmq_pkg;

  // fixed field widths
  localparam int IDX_W  = 11;
  localparam int DATA_W = 32;

  // default tree capacity and element count after reset
  localparam int DEFAULT_CAPACITY = 1024;
  localparam int RESET_COUNT      = 1024;

  // neutral values for min and max
  localparam logic signed [DATA_W-1:0] MIN_NEUTRAL = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] MAX_NEUTRAL = 32'sh8000_0000;

  // command codes
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_MIN   = 2'd1;
  localparam logic [1:0] CMD_MAX   = 2'd2;

  typedef struct packed {
    logic [1:0]               cmd;
    logic [IDX_W-1:0]         first_index;
    logic [IDX_W-1:0]         last_index;
    logic signed [DATA_W-1:0] write_value;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] answer;
    logic                     empty_range;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic clear_step;
    logic start_write;
    logic write_step;
    logic start_query;
    logic query_step;
    logic load_out;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic write_ok;
    logic range_empty;
    logic at_root;
    logic query_done;
  } dp_status_t;

endpackage

// ===== design/rmmq_datapath.sv =====
module rmmq_datapath import rmmq_pkg::*; #(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [IDX_W-1:0] cfg_wr_data,
  input  in_item_t         in_data,
  input  ctrl_cmd_t        ctl,
  output dp_status_t       sts,
  output out_item_t        out_data
);

  localparam int DEPTH = 2 * CAPACITY;
  localparam int NW    = $clog2(DEPTH);
  localparam logic [NW-1:0] LAST_NODE = NW'(DEPTH - 1);
  localparam logic [IDX_W-1:0] EC_RESET =
    IDX_W'((RESET_COUNT > CAPACITY) ? CAPACITY : RESET_COUNT);

  // node stores
  logic signed [DATA_W-1:0] min_mem [DEPTH];
  logic signed [DATA_W-1:0] max_mem [DEPTH];
  logic signed [DATA_W-1:0] min_rd_a, min_rd_b, max_rd_a, max_rd_b;

  logic [IDX_W-1:0]         element_count;
  logic [NW-1:0]            clear_cnt;
  logic [NW-1:0]            cur;
  logic signed [DATA_W-1:0] known_min, known_max;
  logic [NW:0]              l, r;
  logic                     pend_a, pend_b;
  logic                     want_max;
  logic signed [DATA_W-1:0] acc;
  logic                     empty;

  logic [IDX_W-1:0]         lo, hi;
  logic [NW-1:0]            leaf, parent;
  logic [NW:0]              q_l0, q_r0, r_m1;
  logic                     issue;
  logic [NW-1:0]            addr_a, addr_b, waddr;
  logic                     we;
  logic signed [DATA_W-1:0] wmin, wmax, new_min, new_max;
  logic signed [DATA_W-1:0] sel_a, sel_b, acc1, acc2;

  // input decode and range clipping
  always_comb begin
    lo     = (in_data.first_index == '0) ? IDX_W'(1) : in_data.first_index;
    hi     = (in_data.last_index > element_count) ? element_count : in_data.last_index;
    leaf   = NW'(CAPACITY) + NW'(in_data.first_index) - NW'(1);
    q_l0   = (NW+1)'(CAPACITY) + (NW+1)'(lo) - (NW+1)'(1);
    q_r0   = (NW+1)'(CAPACITY) + (NW+1)'(hi);
    parent = cur >> 1;
    issue  = l < r;
    r_m1   = r - (NW+1)'(1);
  end

  assign sts.clear_last  = clear_cnt == LAST_NODE;
  assign sts.write_ok    = (in_data.first_index != '0) &&
                           (in_data.first_index <= element_count);
  assign sts.range_empty = lo > hi;
  assign sts.at_root     = parent == NW'(1);
  assign sts.query_done  = !issue && !pend_a && !pend_b;

  // path update values
  assign new_min = (min_rd_a < known_min) ? min_rd_a : known_min;
  assign new_max = (max_rd_a > known_max) ? max_rd_a : known_max;

  // read addresses and write port
  always_comb begin
    addr_b = r_m1[NW-1:0];
    if (ctl.start_write) begin
      addr_a = leaf ^ NW'(1);
    end else if (ctl.write_step) begin
      addr_a = parent ^ NW'(1);
    end else begin
      addr_a = l[NW-1:0];
    end
    we    = 1'b0;
    waddr = clear_cnt;
    wmin  = MIN_NEUTRAL;
    wmax  = MAX_NEUTRAL;
    if (ctl.clear_step) begin
      we = 1'b1;
    end else if (ctl.start_write) begin
      we    = 1'b1;
      waddr = leaf;
      wmin  = in_data.write_value;
      wmax  = in_data.write_value;
    end else if (ctl.write_step) begin
      we    = 1'b1;
      waddr = parent;
      wmin  = new_min;
      wmax  = new_max;
    end
  end

  // accumulate the node values that arrive this cycle
  always_comb begin
    sel_a = want_max ? max_rd_a : min_rd_a;
    sel_b = want_max ? max_rd_b : min_rd_b;
    acc1  = acc;
    if (pend_a) begin
      if (want_max) begin
        acc1 = (sel_a > acc) ? sel_a : acc;
      end else begin
        acc1 = (sel_a < acc) ? sel_a : acc;
      end
    end
    acc2 = acc1;
    if (pend_b) begin
      if (want_max) begin
        acc2 = (sel_b > acc1) ? sel_b : acc1;
      end else begin
        acc2 = (sel_b < acc1) ? sel_b : acc1;
      end
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (we) begin
      min_mem[waddr] <= wmin;
      max_mem[waddr] <= wmax;
    end
    min_rd_a <= min_mem[addr_a];
    min_rd_b <= min_mem[addr_b];
    max_rd_a <= max_mem[addr_a];
    max_rd_b <= max_mem[addr_b];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      element_count <= EC_RESET;
      clear_cnt     <= '0;
    end else begin
      if (cfg_wr_en) begin
        element_count <= (int'(cfg_wr_data) > CAPACITY) ? IDX_W'(CAPACITY) : cfg_wr_data;
      end
      if (ctl.clear_step) begin
        clear_cnt <= clear_cnt + NW'(1);
      end
    end
  end

  // walk and query registers
  always_ff @(posedge clk) begin
    if (ctl.start_write) begin
      cur       <= leaf;
      known_min <= in_data.write_value;
      known_max <= in_data.write_value;
    end else if (ctl.write_step) begin
      cur       <= parent;
      known_min <= new_min;
      known_max <= new_max;
    end
    if (ctl.start_query) begin
      l        <= q_l0;
      r        <= q_r0;
      pend_a   <= 1'b0;
      pend_b   <= 1'b0;
      want_max <= in_data.cmd == CMD_MAX;
      acc      <= (in_data.cmd == CMD_MAX) ? MAX_NEUTRAL : MIN_NEUTRAL;
      empty    <= sts.range_empty;
    end else if (ctl.query_step) begin
      pend_a <= issue && l[0];
      pend_b <= issue && r[0];
      acc    <= acc2;
      if (issue) begin
        l <= (l + (NW+1)'(l[0])) >> 1;
        r <= r >> 1;
      end
    end
    if (ctl.load_out) begin
      out_data.answer      <= acc;
      out_data.empty_range <= empty;
    end
  end

  // query bounds never cross while stepping
  a_bounds: assert property (@(posedge clk) disable iff (rst)
    ctl.query_step |-> l <= r)
    else $error("query bounds crossed");

  // an update step always starts below the root
  a_walk: assert property (@(posedge clk) disable iff (rst)
    ctl.write_step |-> cur >= NW'(2))
    else $error("update walk above root");

  // no pending reads once the query reports done
  a_done: assert property (@(posedge clk) disable iff (rst)
    (ctl.query_step && sts.query_done) |=> !pend_a && !pend_b)
    else $error("query done with pending reads");

endmodule

// ===== design/rmmq_ctrl.sv =====
module rmmq_ctrl import rmmq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_cmd,
  output logic       out_valid,
  input  logic       out_stall,
  output ctrl_cmd_t  ctl,
  input  dp_status_t sts
);

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_WRITE  = 5'b00100,
    S_QUERY  = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t state, state_next;
  logic   is_query;
  logic   out_free;

  assign in_stall = state != S_IDLE;
  assign is_query = (in_cmd == CMD_MIN) || (in_cmd == CMD_MAX);
  assign out_free = !out_valid || !out_stall;

  // command decode and next state
  always_comb begin
    state_next = state;
    ctl        = '0;
    unique case (state)
      S_CLEAR: begin
        ctl.clear_step = 1'b1;
        if (sts.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          if (in_cmd == CMD_WRITE && sts.write_ok) begin
            ctl.start_write = 1'b1;
            state_next      = S_WRITE;
          end else if (is_query) begin
            ctl.start_query = 1'b1;
            state_next      = sts.range_empty ? S_FINISH : S_QUERY;
          end
        end
      end
      S_WRITE: begin
        ctl.write_step = 1'b1;
        if (sts.at_root) begin
          state_next = S_IDLE;
        end
      end
      S_QUERY: begin
        ctl.query_step = 1'b1;
        if (sts.query_done) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          ctl.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // the update walk continues until the root is written
  a_walk: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE && !sts.at_root) |=> state == S_WRITE)
    else $error("update walk left early");

  // an empty query goes straight to the result
  a_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && in_valid && is_query && sts.range_empty) |=> state == S_FINISH)
    else $error("empty query not finished at once");

  // a result is only loaded when the output register is free
  a_load: assert property (@(posedge clk) disable iff (rst)
    ctl.load_out |-> out_free)
    else $error("result overwritten");

endmodule

// ===== design/range_min_max_query_tree_core.sv =====
// range min/max segment tree: point writes and min/max queries over an inclusive range
// write: the leaf is written on accept, then one node per cycle up to the root
// query: an empty range goes straight to the result; the next input is taken in the cycle
// after the result loads; a stalled result holds the input
// reset: synchronous; a clearing pass over all 2*CAPACITY nodes sets every node to neutral,
// during which no item is taken; element count resets to 1024 (capped at CAPACITY)
module range_min_max_query_tree_core import rmmq_pkg::*; #(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data,
  input  logic             cfg_wr_en,
  input  logic [IDX_W-1:0] cfg_wr_data
);

  ctrl_cmd_t  ctl;
  dp_status_t sts;

  // sequencer
  rmmq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_cmd    (in_data.cmd),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctl       (ctl),
    .sts       (sts)
  );

  // node memory and arithmetic
  rmmq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_data     (in_data),
    .ctl         (ctl),
    .sts         (sts),
    .out_data    (out_data)
  );

endmodule
